// ----- rtl/lgge_pkg.sv -----
`timescale 1ns / 1ps

package lgge_pkg;

	// Field and register widths
	localparam int CFG_W   = 7;
	localparam int COORD_W = 6;
	localparam int REQ_W   = 2;
	localparam int CNT_W   = 4;

	// Default grid bounds
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	// Default active area after reset
	localparam int RESET_SIZE = 64;

	// Stream payload widths
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	// B3/S23 neighbour counts
	localparam logic [CNT_W-1:0] BORN_COUNT = CNT_W'(3);
	localparam logic [CNT_W-1:0] KEEP_COUNT = CNT_W'(2);

	// Configuration register indexes
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE   = 2'd0,
		REQ_TOGGLE  = 2'd1,
		REQ_ADVANCE = 2'd2,
		REQ_READ    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_POST
	} state_t;

	// Sweep control broadcast to every row cell
	typedef struct packed {
		logic             advance;
		logic [CFG_W-1:0] height;
	} sweep_ctl_t;

	// Single-cell access broadcast to every row cell
	typedef struct packed {
		logic               en;
		req_t               req;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               value;
	} access_t;

endpackage

// ----- rtl/lgge_row_cell.sv -----
`timescale 1ns / 1ps

module lgge_row_cell #(
	parameter int WIDTH   = lgge_pkg::DEF_MAX_WIDTH,
	parameter int ROW_IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgge_pkg::sweep_ctl_t sweep,
	input  lgge_pkg::access_t    acc,
	input  logic [WIDTH-1:0]     chain_in,
	input  logic [WIDTH-1:0]     new_row,
	output logic [WIDTH-1:0]     row,
	output logic                 rd_bit
);

	localparam int RIDX_W = $clog2(ROW_IDX + 2);
	localparam int RCMP_W = ((RIDX_W > lgge_pkg::CFG_W) ? RIDX_W : lgge_pkg::CFG_W) + 1;
	localparam int CIDX_W = $clog2(WIDTH + 1);
	localparam int CCMP_W = ((CIDX_W > lgge_pkg::COORD_W) ? CIDX_W : lgge_pkg::COORD_W) + 1;
	localparam logic [RCMP_W-1:0] MY_IDX = RCMP_W'(ROW_IDX);

	logic [WIDTH-1:0]  row_q;
	logic [WIDTH-1:0]  row_acc;
	logic [WIDTH-1:0]  col_sel;
	logic [RCMP_W-1:0] h_c;
	logic              is_last;
	logic              take_chain;
	logic              row_hit;

	// Place of this row within the active area
	assign h_c        = RCMP_W'(sweep.height);
	assign is_last    = (MY_IDX == h_c - RCMP_W'(1));
	assign take_chain = (MY_IDX < h_c - RCMP_W'(1));
	assign row_hit    = acc.en && (RCMP_W'(acc.y) == MY_IDX);

	// Decode the addressed column
	always_comb begin
		for (int j = 0; j < WIDTH; j++) begin
			col_sel[j] = (CCMP_W'(acc.x) == CCMP_W'(j));
		end
	end

	// Apply a single-cell request to the row
	always_comb begin
		row_acc = row_q;
		case (acc.req)
			lgge_pkg::REQ_WRITE:  row_acc = (row_q & ~col_sel) | (col_sel & {WIDTH{acc.value}});
			lgge_pkg::REQ_TOGGLE: row_acc = row_q ^ col_sel;
			default:              row_acc = row_q;
		endcase
	end

	assign rd_bit = row_hit && (|(row_acc & col_sel));
	assign row    = row_q;

	// Hold, shift down the chain, take the new row, or take an access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (sweep.advance) begin
			if (take_chain) begin
				row_q <= chain_in;
			end else if (is_last) begin
				row_q <= new_row;
			end
		end else if (row_hit) begin
			row_q <= row_acc;
		end
	end

endmodule

// ----- rtl/lgge_next_row.sv -----
`timescale 1ns / 1ps

module lgge_next_row #(
	parameter int WIDTH = lgge_pkg::DEF_MAX_WIDTH
) (
	input  logic [WIDTH-1:0] prev_row,
	input  logic [WIDTH-1:0] this_row,
	input  logic [WIDTH-1:0] next_row,
	input  logic [WIDTH-1:0] col_mask,
	output logic [WIDTH-1:0] new_row
);

	logic [WIDTH+1:0]           pp;
	logic [WIDTH+1:0]           tt;
	logic [WIDTH+1:0]           nn;
	logic [WIDTH-1:0]           rule_row;
	logic [lgge_pkg::CNT_W-1:0] cnt [WIDTH];

	// Pad the masked rows with a dead column on each side
	assign pp = {1'b0, prev_row & col_mask, 1'b0};
	assign tt = {1'b0, this_row & col_mask, 1'b0};
	assign nn = {1'b0, next_row & col_mask, 1'b0};

	// Count eight neighbours and apply the rule, one lane per column
	always_comb begin
		for (int j = 0; j < WIDTH; j++) begin
			cnt[j] = lgge_pkg::CNT_W'(pp[j]) + lgge_pkg::CNT_W'(pp[j+1])
			       + lgge_pkg::CNT_W'(pp[j+2]) + lgge_pkg::CNT_W'(tt[j])
			       + lgge_pkg::CNT_W'(tt[j+2]) + lgge_pkg::CNT_W'(nn[j])
			       + lgge_pkg::CNT_W'(nn[j+1]) + lgge_pkg::CNT_W'(nn[j+2]);
			rule_row[j] = (cnt[j] == lgge_pkg::BORN_COUNT)
			           || (tt[j+1] && (cnt[j] == lgge_pkg::KEEP_COUNT));
		end
	end

	// Keep columns outside the active area as stored
	assign new_row = (rule_row & col_mask) | (this_row & ~col_mask);

endmodule

// ----- rtl/life_grid_generation_engine_unit.sv -----
`timescale 1ns / 1ps

// B3/S23 life grid held in a chain of row cells, one row of MAX_WIDTH cell bits per
// chain cell, cleared to all dead at reset. Write, toggle and read requests are
// accepted back to back while the result path is free; the cell at (cell_x, cell_y)
// is updated in place and its new state returned. An advance shifts the active rows
// down the chain one per cycle through a single next-row unit that sees the old row
// above, the row itself and the row below, and returns the new row to the far end of
// the active part of the chain. Coordinates outside the active area leave the grid
// untouched and return coord_error set. The user must write configuration only while
// the block is idle; the block itself does not enforce it. A size of zero acts as one
// and a size above the bound acts as the bound.
module life_grid_generation_engine_unit #(
	parameter int MAX_WIDTH  = lgge_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lgge_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [5:0] cell_x, [11:6] cell_y, [12] cell_value, [15:13] zero
	input  logic [lgge_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] req_type
	input  logic [lgge_pkg::REQ_W-1:0]     s_tuser,
	// Result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] cell_state, [7:1] zero
	output logic [lgge_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] coord_error
	output logic                           m_tuser,
	// Configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [lgge_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CFG_MAXV = (1 << lgge_pkg::CFG_W) - 1;
	localparam logic [lgge_pkg::CFG_W-1:0] W_LIMIT =
		lgge_pkg::CFG_W'((MAX_WIDTH > CFG_MAXV) ? CFG_MAXV : MAX_WIDTH);
	localparam logic [lgge_pkg::CFG_W-1:0] H_LIMIT =
		lgge_pkg::CFG_W'((MAX_HEIGHT > CFG_MAXV) ? CFG_MAXV : MAX_HEIGHT);
	localparam logic [lgge_pkg::CFG_W-1:0] W_RESET =
		lgge_pkg::CFG_W'((lgge_pkg::RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : lgge_pkg::RESET_SIZE);
	localparam logic [lgge_pkg::CFG_W-1:0] H_RESET =
		lgge_pkg::CFG_W'((lgge_pkg::RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : lgge_pkg::RESET_SIZE);
	localparam int CIDX_W = $clog2(MAX_WIDTH + 1);
	localparam int CCMP_W = ((CIDX_W > lgge_pkg::CFG_W) ? CIDX_W : lgge_pkg::CFG_W) + 1;

	lgge_pkg::state_t     state_q;
	lgge_pkg::state_t     state_d;
	lgge_pkg::req_t       in_req;
	lgge_pkg::sweep_ctl_t sweep;
	lgge_pkg::access_t    acc;

	logic [lgge_pkg::CFG_W-1:0]   w_q;
	logic [lgge_pkg::CFG_W-1:0]   h_q;
	logic [lgge_pkg::CFG_W-1:0]   cfg_clamped;
	logic [lgge_pkg::CFG_W-1:0]   step_q;
	logic [lgge_pkg::COORD_W-1:0] in_x;
	logic [lgge_pkg::COORD_W-1:0] in_y;
	logic                         in_value;
	logic                         in_fire;
	logic                         coord_bad;
	logic                         last_step;
	logic                         slot_free;
	logic                         res_drain;
	logic                         res_load_acc;
	logic                         res_load_post;
	logic                         res_valid_q;
	logic                         res_state_q;
	logic                         res_err_q;
	logic                         m_valid_q;
	logic                         m_state_q;
	logic                         m_err_q;
	logic                         rd_any;
	logic                         sweep_adv;

	logic [MAX_WIDTH-1:0] rows [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] chain [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] prev_q;
	logic [MAX_WIDTH-1:0] next_row;
	logic [MAX_WIDTH-1:0] new_row;
	logic [MAX_WIDTH-1:0] col_mask;
	logic [MAX_HEIGHT-1:0] rd_vec;

	// Unpack the request
	assign in_req   = lgge_pkg::req_t'(s_tuser);
	assign in_x     = s_tdata[lgge_pkg::COORD_W-1:0];
	assign in_y     = s_tdata[2*lgge_pkg::COORD_W-1:lgge_pkg::COORD_W];
	assign in_value = s_tdata[2*lgge_pkg::COORD_W];
	assign in_fire  = s_tvalid && s_tready;

	assign coord_bad = ({1'b0, in_x} >= w_q) || ({1'b0, in_y} >= h_q);

	// Clamp and store configuration
	assign cfg_ready   = 1'b1;
	assign cfg_clamped = (cfg_data == '0) ? lgge_pkg::CFG_W'(1)
	                   : (cfg_data > W_LIMIT && cfg_index == lgge_pkg::CFG_IDX_WIDTH) ? W_LIMIT
	                   : (cfg_data > H_LIMIT && cfg_index == lgge_pkg::CFG_IDX_HEIGHT) ? H_LIMIT
	                   : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_RESET;
			h_q <= H_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lgge_pkg::CFG_IDX_WIDTH:  w_q <= cfg_clamped;
				lgge_pkg::CFG_IDX_HEIGHT: h_q <= cfg_clamped;
				default:                  w_q <= w_q;
			endcase
		end
	end

	// Active column mask
	always_comb begin
		for (int j = 0; j < MAX_WIDTH; j++) begin
			col_mask[j] = (CCMP_W'(j) < CCMP_W'(w_q));
		end
	end

	// Result slot handshake
	assign res_drain = res_valid_q && (!m_valid_q || m_tready);
	assign slot_free = !res_valid_q || res_drain;
	assign last_step = (step_q == h_q - lgge_pkg::CFG_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lgge_pkg::ST_IDLE:  if (in_fire && in_req == lgge_pkg::REQ_ADVANCE) state_d = lgge_pkg::ST_SWEEP;
			lgge_pkg::ST_SWEEP: if (last_step) state_d = lgge_pkg::ST_POST;
			lgge_pkg::ST_POST:  if (slot_free) state_d = lgge_pkg::ST_IDLE;
			default:            state_d = lgge_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		s_tready      = 1'b0;
		sweep_adv     = 1'b0;
		res_load_post = 1'b0;
		case (state_q)
			lgge_pkg::ST_IDLE:  s_tready = slot_free;
			lgge_pkg::ST_SWEEP: sweep_adv = 1'b1;
			lgge_pkg::ST_POST:  res_load_post = slot_free;
			default:            s_tready = 1'b0;
		endcase
	end

	// Sweep control: advance flag, then active height
	assign sweep = {sweep_adv, h_q};

	// Broadcast the cell access: enable, request, x, y, value
	assign acc = {in_fire && (in_req != lgge_pkg::REQ_ADVANCE) && !coord_bad,
	              in_req, in_x, in_y, in_value};

	assign res_load_acc = in_fire && (in_req != lgge_pkg::REQ_ADVANCE);

	// Row chain
	genvar gi;
	generate
		for (gi = 0; gi < MAX_HEIGHT; gi++) begin : g_row
			if (gi < MAX_HEIGHT - 1) begin : g_link
				assign chain[gi] = rows[gi+1];
			end else begin : g_end
				assign chain[gi] = '0;
			end

			lgge_row_cell #(
				.WIDTH   (MAX_WIDTH),
				.ROW_IDX (gi)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.sweep    (sweep),
				.acc      (acc),
				.chain_in (chain[gi]),
				.new_row  (new_row),
				.row      (rows[gi]),
				.rd_bit   (rd_vec[gi])
			);
		end
	endgenerate

	assign rd_any   = |rd_vec;
	assign next_row = last_step ? '0 : rows[1];

	// New row from the head of the chain
	lgge_next_row #(
		.WIDTH (MAX_WIDTH)
	) u_next (
		.prev_row (prev_q),
		.this_row (rows[0]),
		.next_row (next_row),
		.col_mask (col_mask),
		.new_row  (new_row)
	);

	// Sweep counter and old row above
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgge_pkg::ST_IDLE;
			step_q  <= '0;
			prev_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lgge_pkg::ST_SWEEP) begin
				step_q <= step_q + lgge_pkg::CFG_W'(1);
				prev_q <= rows[0];
			end else begin
				step_q <= '0;
				prev_q <= '0;
			end
		end
	end

	// Result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load_acc || res_load_post) begin
			res_valid_q <= 1'b1;
		end else if (res_drain) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load_acc) begin
			res_state_q <= rd_any;
			res_err_q   <= coord_bad;
		end else if (res_load_post) begin
			res_state_q <= 1'b0;
			res_err_q   <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_drain) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_drain) begin
			m_state_q <= res_state_q;
			m_err_q   <= res_err_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(lgge_pkg::M_TDATA_W-1){1'b0}}, m_state_q};
	assign m_tuser  = m_err_q;

`ifndef SYNTHESIS
	// A pending result is never overwritten
	a_slot_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load_acc || res_load_post) |-> (!res_valid_q || res_drain))
		else $error("result slot overwritten");

	// The sweep never runs past the active rows
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lgge_pkg::ST_SWEEP) |-> (step_q < h_q))
		else $error("sweep step beyond active height");

	// A cell access never coincides with a sweep
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc.en && sweep.advance))
		else $error("cell access during sweep");

	// An accepted advance starts the sweep next cycle
	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_req == lgge_pkg::REQ_ADVANCE) |=> (state_q == lgge_pkg::ST_SWEEP))
		else $error("advance did not start a sweep");
`endif

endmodule

// ----- verif/life_grid_generation_engine_unit_test.sv -----
`timescale 1ns / 1ps

module life_grid_generation_engine_unit_test;
	import lgge_pkg::*;

	localparam int WATCHDOG_CYCLES    = 3000;
	localparam int RESULT_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES       = 80;

	typedef struct packed {
		logic cell_state;
		logic coord_error;
	} cell_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [REQ_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_index = 1'b0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Shadow copy of the grid and its size registers
	logic [DEF_MAX_WIDTH-1:0] life_cells [0:DEF_MAX_HEIGHT-1];
	logic [CFG_W-1:0]         grid_cols = CFG_W'(RESET_SIZE);
	logic [CFG_W-1:0]         grid_rows = CFG_W'(RESET_SIZE);
	cell_reply_t              pending_replies [$];

	int mismatch_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	life_grid_generation_engine_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int r = 0; r < DEF_MAX_HEIGHT; r++) life_cells[r] = '0;
	end

	// Zero acts as one, anything above the bound acts as the bound
	function automatic int active_span(logic [CFG_W-1:0] raw, int bound);
		if (raw == 0) return 1;
		if (raw > bound) return bound;
		return raw;
	endfunction

	// Next B3/S23 generation of the active area, outside cells dead and untouched
	task automatic step_generation();
		logic [DEF_MAX_WIDTH-1:0] old_rows [0:DEF_MAX_HEIGHT-1];
		int w;
		int h;
		int n;
		int xx;
		int yy;
		old_rows = life_cells;
		w = active_span(grid_cols, DEF_MAX_WIDTH);
		h = active_span(grid_rows, DEF_MAX_HEIGHT);
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				n = 0;
				for (int dy = -1; dy <= 1; dy++) begin
					for (int dx = -1; dx <= 1; dx++) begin
						yy = y + dy;
						xx = x + dx;
						if ((dx != 0 || dy != 0) && yy >= 0 && yy < h && xx >= 0 && xx < w)
							n += old_rows[yy][xx];
					end
				end
				life_cells[y][x] = (n == 3) || (old_rows[y][x] && n == 2);
			end
		end
	endtask

	// Apply one accepted request to the shadow grid and work out its reply
	task automatic apply_life_request(req_t kind, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic value, output cell_reply_t reply);
		int w;
		int h;
		w = active_span(grid_cols, DEF_MAX_WIDTH);
		h = active_span(grid_rows, DEF_MAX_HEIGHT);
		reply = '0;
		if (kind == REQ_ADVANCE) begin
			step_generation();
		end else if (x >= w || y >= h) begin
			reply.coord_error = 1'b1;
		end else begin
			case (kind)
				REQ_WRITE: begin
					life_cells[y][x] = value;
				end
				REQ_TOGGLE: begin
					life_cells[y][x] = ~life_cells[y][x];
				end
				default: begin
				end
			endcase
			reply.cell_state = life_cells[y][x];
		end
	endtask

	// Offer one request, hold it until taken, then record its reply
	task automatic offer_request(req_t kind, int x, int y, logic value);
		cell_reply_t reply;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, value, COORD_W'(y), COORD_W'(x)};
		do @(posedge clk); while (!s_tready);
		apply_life_request(kind, COORD_W'(x), COORD_W'(y), value, reply);
		pending_replies.push_back(reply);
	endtask

	// Drop the request line and wait until every reply is back
	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	task automatic write_register(logic idx, logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_IDX_WIDTH) grid_cols = value;
		else grid_rows = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_grid_size(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
		wait_for_replies();
		write_register(CFG_IDX_WIDTH, cols);
		write_register(CFG_IDX_HEIGHT, rows);
	endtask

	task automatic test_cell_access_edges();
		set_grid_size(CFG_W'(64), CFG_W'(64));
		offer_request(REQ_WRITE, 0, 0, 1'b1);
		offer_request(REQ_WRITE, 63, 63, 1'b1);
		offer_request(REQ_READ, 63, 63, 1'b0);
		offer_request(REQ_TOGGLE, 63, 0, 1'b1);
		offer_request(REQ_TOGGLE, 63, 0, 1'b0);
		offer_request(REQ_ADVANCE, 63, 63, 1'b1);
		offer_request(REQ_READ, 0, 0, 1'b1);
	endtask

	task automatic test_blinker_oscillates();
		offer_request(REQ_WRITE, 10, 10, 1'b1);
		offer_request(REQ_WRITE, 11, 10, 1'b1);
		offer_request(REQ_WRITE, 12, 10, 1'b1);
		offer_request(REQ_ADVANCE, 0, 0, 1'b0);
		offer_request(REQ_READ, 11, 9, 1'b0);
		offer_request(REQ_READ, 10, 10, 1'b0);
	endtask

	// Zero acts as one, oversize acts as the bound
	task automatic test_size_register_clamp();
		set_grid_size(CFG_W'(0), CFG_W'(0));
		offer_request(REQ_WRITE, 0, 0, 1'b1);
		offer_request(REQ_TOGGLE, 1, 0, 1'b1);
		offer_request(REQ_READ, 0, 63, 1'b0);
		offer_request(REQ_ADVANCE, 0, 0, 1'b0);
		offer_request(REQ_READ, 0, 0, 1'b0);
		set_grid_size(CFG_W'(127), CFG_W'(127));
		offer_request(REQ_WRITE, 63, 63, 1'b1);
	endtask

	// Cells beyond the active columns are neither counted nor changed
	task automatic test_inactive_cells_kept();
		set_grid_size(CFG_W'(64), CFG_W'(64));
		offer_request(REQ_WRITE, 22, 1, 1'b1);
		offer_request(REQ_WRITE, 22, 2, 1'b1);
		offer_request(REQ_WRITE, 22, 3, 1'b1);
		offer_request(REQ_WRITE, 24, 1, 1'b1);
		offer_request(REQ_WRITE, 24, 2, 1'b1);
		set_grid_size(CFG_W'(24), CFG_W'(64));
		offer_request(REQ_ADVANCE, 0, 0, 1'b0);
		set_grid_size(CFG_W'(64), CFG_W'(64));
		offer_request(REQ_READ, 23, 2, 1'b0);
		offer_request(REQ_READ, 23, 1, 1'b0);
		offer_request(REQ_READ, 24, 2, 1'b0);
	endtask

	// Stall results for a long stretch while requests keep coming
	task automatic test_result_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_seq++;
		for (int i = 0; i < 24; i++)
			offer_request(i % 3 == 0 ? REQ_TOGGLE : REQ_READ, i, 2 * i, 1'b1);
		offer_request(REQ_ADVANCE, 0, 0, 1'b0);
		wait_for_replies();
	endtask

	task automatic pick_random_size();
		logic [CFG_W-1:0] dims [2];
		for (int i = 0; i < 2; i++) begin
			case ($urandom_range(9))
				0: dims[i] = '0;
				1: dims[i] = CFG_W'(64);
				2: dims[i] = CFG_W'($urandom_range(127, 65));
				default: dims[i] = CFG_W'($urandom_range(64, 1));
			endcase
		end
		set_grid_size(dims[0], dims[1]);
	endtask

	// Writes, toggles and reads clustered in a small window so patterns evolve, plus advances and noise
	task automatic random_phase(int n_items);
		int w;
		int h;
		int wx;
		int wy;
		int x;
		int y;
		int pick;
		w  = active_span(grid_cols, DEF_MAX_WIDTH);
		h  = active_span(grid_rows, DEF_MAX_HEIGHT);
		wx = $urandom_range(w - 1);
		wy = $urandom_range(h - 1);
		repeat (n_items) begin
			x = wx + $urandom_range(7);
			y = wy + $urandom_range(7);
			if (x >= w) x = $urandom_range(w - 1);
			if (y >= h) y = $urandom_range(h - 1);
			pick = $urandom_range(99);
			if (pick < 9)
				offer_request(REQ_ADVANCE, $urandom_range(63), $urandom_range(63),
					1'($urandom));
			else if (pick < 50)
				offer_request(REQ_WRITE, x, y, $urandom_range(99) < 55);
			else if (pick < 64)
				offer_request(REQ_TOGGLE, x, y, 1'($urandom));
			else if (pick < 88)
				offer_request(REQ_READ, x, y, 1'($urandom));
			else begin
				case ($urandom_range(2))
					0: offer_request(REQ_WRITE, $urandom_range(63), $urandom_range(63),
						1'($urandom));
					1: offer_request(REQ_TOGGLE, $urandom_range(63), $urandom_range(63),
						1'($urandom));
					default: offer_request(REQ_READ, $urandom_range(63), $urandom_range(63),
						1'($urandom));
				endcase
			end
		end
	endtask

	task automatic test_random_traffic(int tx_pct, int rx_pct, int phases);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (phases) begin
			pick_random_size();
			random_phase(40);
		end
	endtask

	// Result acceptor with random stalls and an occasional long hold-off
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = RESULT_HOLD_CYCLES;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare each result with the oldest outstanding reply
	always @(posedge clk) begin : check_replies
		cell_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b",
					$time, m_tdata, m_tuser);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (m_tdata !== M_TDATA_W'(want.cell_state)) begin
					$display("%0t: cell_state mismatch, expected tdata=%h actual tdata=%h",
						$time, M_TDATA_W'(want.cell_state), m_tdata);
					mismatch_count++;
				end
				if (m_tuser !== want.coord_error) begin
					$display("%0t: coord_error mismatch, expected %b actual %b",
						$time, want.coord_error, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// Abort when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("life_grid_generation_engine_unit_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		rx_idle_pct = 0;
		test_cell_access_edges();
		test_blinker_oscillates();
		test_size_register_clamp();
		test_inactive_cells_kept();
		test_result_backpressure();
		test_random_traffic(36, 86, 6);
		test_random_traffic(86, 36, 6);
		test_random_traffic(0, 0, 5);
		wait_for_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("life_grid_generation_engine_unit_test OK");
		else
			$display("life_grid_generation_engine_unit_test NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lgge_pkg.sv
rtl/lgge_row_cell.sv
rtl/lgge_next_row.sv
rtl/life_grid_generation_engine_unit.sv
verif/life_grid_generation_engine_unit_test.sv
